// ===== design/mpsf_pkg.sv =====
// Shared types, constants and the byte compare function of the substring finder.
`default_nettype none

package mpsf_pkg;

   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 4;
   localparam int REG_SLOTS    = 4;
   localparam int PATTERN_W    = 64;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int ACTIVE_W     = 3;
   localparam int LENGTHS_W    = 16;
   localparam int SLOT_W       = 2;
   localparam int RESULT_POS_W = 32;
   localparam int TOTAL_W      = 32;
   localparam int JOB_DEPTH    = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE,
      CSR_LENGTHS,
      CSR_PATTERN_0,
      CSR_PATTERN_1,
      CSR_PATTERN_2,
      CSR_PATTERN_3
   } csr_index_type;

   typedef enum logic {
      KIND_MATCH,
      KIND_TOTAL
   } result_kind_type;

   // True when the byte lying back places behind the current one agrees with the pattern,
   // or when that place lies outside a pattern of length len.
   function automatic logic byte_hit(
      input logic [BYTE_W-1:0]    byt,
      input logic                 valid,
      input logic [LEN_W-1:0]     back,
      input logic [LEN_W-1:0]     len,
      input logic [PATTERN_W-1:0] pat
   );
      logic [LEN_W-1:0]  idx;
      logic [BYTE_W-1:0] want;
      idx  = len - back - LEN_W'(1);
      want = pat[{idx[2:0], 3'b000} +: BYTE_W];
      return (back >= len) || (valid && (byt == want));
   endfunction

endpackage

`default_nettype wire

// ===== design/mpsf_cell.sv =====
// One window cell: holds a past text byte, compares it for every slot, passes it on.
`default_nettype none

module mpsf_cell #(
   parameter int SLOTS = 4,
   parameter int BACK  = 1
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        advance,
   input  wire logic                                        clear,
   input  wire logic [mpsf_pkg::BYTE_W-1:0]                 byte_in,
   input  wire logic                                        valid_in,
   input  wire logic [SLOTS-1:0][mpsf_pkg::LEN_W-1:0]       slot_len,
   input  wire logic [SLOTS-1:0][mpsf_pkg::PATTERN_W-1:0]   slot_pattern,
   output logic      [mpsf_pkg::BYTE_W-1:0]                 byte_out,
   output logic                                             valid_out,
   output logic      [SLOTS-1:0]                            hit
);
   import mpsf_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in_next;
   logic              valid_ff, valid_in_next;

   always_comb begin
      byte_in_next  = byte_ff;
      valid_in_next = valid_ff;
      if (advance) begin
         byte_in_next  = byte_in;
         valid_in_next = valid_in && !clear;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_next;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         hit[s] = byte_hit(byte_ff, valid_ff, LEN_W'(BACK), slot_len[s], slot_pattern[s]);
      end
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// ===== design/mpsf_job_queue.sv =====
// Register FIFO of match jobs between the window and the result emitter.
`default_nettype none

module mpsf_job_queue #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = store_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== design/mpsf_emitter.sv =====
// Result emitter: walks the head job slot by slot, keeps the match total, drives the rsp register.
`default_nettype none

module mpsf_emitter #(
   parameter int SLOTS         = 4,
   parameter int POSITION_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 head_valid,
   input  wire logic [SLOTS-1:0]                     head_mask,
   input  wire logic                                 head_final,
   input  wire logic [POSITION_BITS-1:0]             head_here,
   input  wire logic [mpsf_pkg::LENGTHS_W-1:0]       lengths,
   output logic                                      pop,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic                                      rsp_result_kind,
   output logic      [mpsf_pkg::SLOT_W-1:0]          rsp_pattern_slot,
   output logic      [mpsf_pkg::RESULT_POS_W-1:0]    rsp_start_position,
   output logic      [mpsf_pkg::TOTAL_W-1:0]         rsp_match_total,
   output logic                                      rsp_run_end
);
   import mpsf_pkg::*;

   localparam int DIFF_W = (POSITION_BITS > RESULT_POS_W) ? POSITION_BITS : RESULT_POS_W;

   logic [SLOTS-1:0]        done_ff, done_in;
   logic [TOTAL_W-1:0]      found_ff, found_in;
   logic                    valid_ff, valid_in;
   result_kind_type         kind_ff, kind_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [RESULT_POS_W-1:0] start_ff, start_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic                    run_end_ff, run_end_in;

   logic [SLOTS-1:0]   remaining, pick_onehot;
   logic [SLOT_W-1:0]  pick_slot;
   logic [LEN_W-1:0]   pick_len;
   logic [TOTAL_W-1:0] found_next;
   logic [DIFF_W-1:0]  match_start;
   logic               emit, last;

   always_comb begin
      remaining   = head_mask & ~done_ff;
      pick_slot   = '0;
      pick_onehot = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (remaining[s]) begin
            pick_slot   = SLOT_W'(s);
            pick_onehot = SLOTS'(1) << s;
         end
      end
      pick_len    = lengths[{pick_slot, 2'b00} +: LEN_W];
      found_next  = (found_ff == '1) ? found_ff : found_ff + TOTAL_W'(1);
      match_start = DIFF_W'(head_here) - DIFF_W'(LEN_W'(pick_len - LEN_W'(1)));
      emit        = head_valid && (!valid_ff || !rsp_stall);

      done_in    = done_ff;
      found_in   = found_ff;
      valid_in   = valid_ff && rsp_stall;
      kind_in    = kind_ff;
      slot_in    = slot_ff;
      start_in   = start_ff;
      total_in   = total_ff;
      run_end_in = run_end_ff;
      last       = 1'b0;
      pop        = 1'b0;

      if (emit) begin
         valid_in = 1'b1;
         if (|remaining) begin
            kind_in  = KIND_MATCH;
            slot_in  = pick_slot;
            start_in = match_start[RESULT_POS_W-1:0];
            total_in = found_next;
            found_in = found_next;
            done_in  = done_ff | pick_onehot;
            last     = ((remaining & ~pick_onehot) == '0) && !head_final;
         end else begin
            kind_in  = KIND_TOTAL;
            slot_in  = '0;
            start_in = '0;
            total_in = found_ff;
            found_in = '0;
            last     = 1'b1;
         end
         run_end_in = last;
         if (last) begin
            pop     = 1'b1;
            done_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         found_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         found_ff <= found_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      slot_ff    <= slot_in;
      start_ff   <= start_in;
      total_ff   <= total_in;
      run_end_ff <= run_end_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_pattern_slot   = slot_ff;
   assign rsp_start_position = start_ff;
   assign rsp_match_total    = total_ff;
   assign rsp_run_end        = run_end_ff;

endmodule

`default_nettype wire

// ===== design/multi_pattern_substring_finder_unit.sv =====
// Top level of the multi-pattern substring finder: registers, cell row, job queue, emitter.
//
// The req channel takes one text byte per transfer, with req_final_byte on the last byte of a
// text. A byte is taken in every cycle while req_stall is low; it is compared at once against
// the current byte and a row of window cells holding the previous bytes.
// Each byte that matches one or more patterns, or ends a text, leaves a job in a four-entry
// queue; bytes without results leave nothing. The emitter sends one result per rsp transfer:
// match reports in ascending slot order, then the total report on a final byte, with
// rsp_run_end on the last result of the byte. A result passes through the job queue and then
// the rsp register after its byte is taken, and results leave at one per cycle while
// rsp_stall is low and the queue holds jobs.
// req_stall rises only while the queue holds four jobs, which happens only when the receiver
// stalls or bytes keep producing more than one result.
// A stalled rsp register holds its result; the queue keeps taking bytes until full.
// Write registers through csr_* only while the block is idle; the block does not enforce it.
// Synchronous reset empties the window, the queue and the output register, zeroes position and
// total, and sets the pattern count to one with all lengths zero.
`default_nettype none

module multi_pattern_substring_finder_unit #(
   parameter int PATTERN_SLOTS     = 4,
   parameter int MAX_PATTERN_BYTES = 8,
   parameter int POSITION_BITS     = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [mpsf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mpsf_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [mpsf_pkg::BYTE_W-1:0]           req_text_byte,
   input  wire logic                                  req_final_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_result_kind,
   output logic      [mpsf_pkg::SLOT_W-1:0]           rsp_pattern_slot,
   output logic      [mpsf_pkg::RESULT_POS_W-1:0]     rsp_start_position,
   output logic      [mpsf_pkg::TOTAL_W-1:0]          rsp_match_total,
   output logic                                       rsp_run_end
);
   import mpsf_pkg::*;

   localparam int SLOTS = (PATTERN_SLOTS < REG_SLOTS) ? PATTERN_SLOTS : REG_SLOTS;
   localparam int JOB_W = SLOTS + 1 + POSITION_BITS;

   logic [ACTIVE_W-1:0]  active_ff, active_in;
   logic [LENGTHS_W-1:0] lengths_ff, lengths_in;
   logic [PATTERN_W-1:0] pattern_ff [REG_SLOTS];
   logic [PATTERN_W-1:0] pattern_in [REG_SLOTS];

   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic [SLOTS-1:0][LEN_W-1:0]     slot_len;
   logic [SLOTS-1:0][PATTERN_W-1:0] slot_pattern;
   logic [BYTE_W-1:0]               win_byte  [MAX_PATTERN_BYTES];
   logic                            win_valid [MAX_PATTERN_BYTES];
   logic [SLOTS-1:0]                back_hit  [MAX_PATTERN_BYTES];
   logic [SLOTS-1:0]                slot_hit;

   logic             accept, advance, push, full, pop, head_valid;
   logic [JOB_W-1:0] head_data;
   logic [SLOTS-1:0] head_mask;
   logic             head_final;
   logic [POSITION_BITS-1:0] head_here;

   // configuration registers
   always_comb begin
      active_in  = active_ff;
      lengths_in = lengths_ff;
      for (int r = 0; r < REG_SLOTS; r++) begin
         pattern_in[r] = pattern_ff[r];
      end
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE:    active_in     = csr_write_data[ACTIVE_W-1:0];
            CSR_LENGTHS:   lengths_in    = csr_write_data[LENGTHS_W-1:0];
            CSR_PATTERN_0: pattern_in[0] = csr_write_data;
            CSR_PATTERN_1: pattern_in[1] = csr_write_data;
            CSR_PATTERN_2: pattern_in[2] = csr_write_data;
            CSR_PATTERN_3: pattern_in[3] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= ACTIVE_W'(1);
         lengths_ff <= '0;
         for (int r = 0; r < REG_SLOTS; r++) begin
            pattern_ff[r] <= '0;
         end
      end else begin
         active_ff  <= active_in;
         lengths_ff <= lengths_in;
         for (int r = 0; r < REG_SLOTS; r++) begin
            pattern_ff[r] <= pattern_in[r];
         end
      end
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_len[s]     = lengths_ff[4*s +: LEN_W];
         slot_pattern[s] = pattern_ff[s];
      end
   end

   // window cell row
   assign accept  = req_valid && !req_stall;
   assign advance = accept;

   assign win_byte[0]  = req_text_byte;
   assign win_valid[0] = 1'b1;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         back_hit[0][s] = byte_hit(req_text_byte, 1'b1, '0, slot_len[s], slot_pattern[s]);
      end
   end

   for (genvar b = 1; b < MAX_PATTERN_BYTES; b++) begin : g_cell
      mpsf_cell #(
         .SLOTS (SLOTS),
         .BACK  (b)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .clear        (req_final_byte),
         .byte_in      (win_byte[b-1]),
         .valid_in     (win_valid[b-1]),
         .slot_len     (slot_len),
         .slot_pattern (slot_pattern),
         .byte_out     (win_byte[b]),
         .valid_out    (win_valid[b]),
         .hit          (back_hit[b])
      );
   end

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_hit[s] = (slot_len[s] != '0)
                    && (slot_len[s] <= LEN_W'(MAX_PATTERN_BYTES))
                    && (ACTIVE_W'(s) < active_ff);
         for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
            slot_hit[s] = slot_hit[s] && back_hit[b][s];
         end
      end
   end

   // text position
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_final_byte) begin
            pos_in = '0;
         end else if (pos_ff != '1) begin
            pos_in = pos_ff + POSITION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // job queue and emitter
   assign push      = accept && ((|slot_hit) || req_final_byte);
   assign req_stall = full;

   mpsf_job_queue #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({slot_hit, req_final_byte, pos_ff}),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_mask  = head_data[JOB_W-1 -: SLOTS];
   assign head_final = head_data[POSITION_BITS];
   assign head_here  = head_data[POSITION_BITS-1:0];

   mpsf_emitter #(
      .SLOTS         (SLOTS),
      .POSITION_BITS (POSITION_BITS)
   ) u_emitter (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_mask          (head_mask),
      .head_final         (head_final),
      .head_here          (head_here),
      .lengths            (lengths_ff),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_pattern_slot   (rsp_pattern_slot),
      .rsp_start_position (rsp_start_position),
      .rsp_match_total    (rsp_match_total),
      .rsp_run_end        (rsp_run_end)
   );

`ifndef NO_ASSERTIONS
   a_total_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_TOTAL)) |-> rsp_run_end)
      else $error("total report without run end");

   a_total_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_TOTAL))
         |-> ((rsp_pattern_slot == '0) && (rsp_start_position == '0)))
      else $error("total report with slot or start set");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_MATCH)) |-> (rsp_match_total != '0))
      else $error("match report with zero total");

   a_final_clears_position: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (pos_ff == '0))
      else $error("text position not cleared after final byte");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/substring_match_checker.sv =====
// Checker of the substring finder: tracks settings, predicts each byte's reports, compares.
module substring_match_checker
   import mpsf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [BYTE_W-1:0]       req_text_byte,
   input  logic                    req_final_byte,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_result_kind,
   input  logic [SLOT_W-1:0]       rsp_pattern_slot,
   input  logic [RESULT_POS_W-1:0] rsp_start_position,
   input  logic [TOTAL_W-1:0]      rsp_match_total,
   input  logic                    rsp_run_end,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      match_reports,
   output int                      total_reports
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PATTERN_BYTES = 8;
   localparam int WINDOW_BYTES  = PATTERN_BYTES - 1;

   typedef struct {
      result_kind_type         kind;
      logic [SLOT_W-1:0]       slot;
      logic [RESULT_POS_W-1:0] start;
      logic [TOTAL_W-1:0]      total;
      logic                    run_end;
   } report_type;

   report_type pending_reports [$];

   logic [ACTIVE_W-1:0]  active_cfg;
   logic [LENGTHS_W-1:0] lengths_cfg;
   logic [PATTERN_W-1:0] pattern_cfg [REG_SLOTS];

   logic [BYTE_W-1:0]       recent_bytes [WINDOW_BYTES];
   int                      held_bytes;
   logic [RESULT_POS_W-1:0] text_offset;
   logic [TOTAL_W-1:0]      found_in_text;

   function automatic void clear_text();
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      held_bytes    = 0;
      text_offset   = '0;
      found_in_text = '0;
   endfunction

   function automatic void scan_text_byte(input logic [BYTE_W-1:0] cur, input logic fin);
      int          slots;
      int          len;
      int          back;
      int          produced;
      logic        hit;
      logic [BYTE_W-1:0] got;
      report_type  r;
      slots    = (active_cfg > REG_SLOTS) ? REG_SLOTS : int'(active_cfg);
      produced = 0;
      for (int s = 0; s < slots; s++) begin
         len = int'(lengths_cfg[LEN_W*s +: LEN_W]);
         if (len == 0 || len > PATTERN_BYTES || held_bytes < len - 1) continue;
         hit = 1'b1;
         for (int i = 0; i < len; i++) begin
            back = len - 1 - i;
            got  = (back == 0) ? cur : recent_bytes[back-1];
            if (got != pattern_cfg[s][BYTE_W*i +: BYTE_W]) hit = 1'b0;
         end
         if (hit) begin
            if (found_in_text != '1) found_in_text++;
            r.kind    = KIND_MATCH;
            r.slot    = SLOT_W'(s);
            r.start   = text_offset - RESULT_POS_W'(len - 1);
            r.total   = found_in_text;
            r.run_end = 1'b0;
            pending_reports.push_back(r);
            produced++;
         end
      end
      if (fin) begin
         r.kind    = KIND_TOTAL;
         r.slot    = '0;
         r.start   = '0;
         r.total   = found_in_text;
         r.run_end = 1'b0;
         pending_reports.push_back(r);
         produced++;
         clear_text();
      end else begin
         for (int i = WINDOW_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
         recent_bytes[0] = cur;
         if (held_bytes < WINDOW_BYTES) held_bytes++;
         if (text_offset != '1) text_offset++;
      end
      if (produced > 0) pending_reports[pending_reports.size()-1].run_end = 1'b1;
   endfunction

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $time, what);
   endfunction

   function automatic void check_report();
      report_type want;
      if (rsp_result_kind == KIND_TOTAL) total_reports++;
      else match_reports++;
      if (pending_reports.size() == 0) begin
         note_failure($sformatf("unexpected report kind=%0d slot=%0d start=%0d total=%0d end=%0b",
            rsp_result_kind, rsp_pattern_slot, rsp_start_position, rsp_match_total,
            rsp_run_end));
      end else begin
         want = pending_reports.pop_front();
         if (rsp_result_kind !== want.kind || rsp_pattern_slot !== want.slot ||
             rsp_start_position !== want.start || rsp_match_total !== want.total ||
             rsp_run_end !== want.run_end) begin
            note_failure($sformatf({"mismatch: expected kind=%0d slot=%0d start=%0d total=%0d ",
               "end=%0b, got kind=%0d slot=%0d start=%0d total=%0d end=%0b"},
               want.kind, want.slot, want.start, want.total, want.run_end,
               rsp_result_kind, rsp_pattern_slot, rsp_start_position, rsp_match_total,
               rsp_run_end));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         active_cfg  = ACTIVE_W'(1);
         lengths_cfg = '0;
         foreach (pattern_cfg[i]) pattern_cfg[i] = '0;
         clear_text();
         pending_reports.delete();
         mismatch_count = 0;
         match_reports  = 0;
         total_reports  = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ACTIVE:    active_cfg  = csr_write_data[ACTIVE_W-1:0];
               CSR_LENGTHS:   lengths_cfg = csr_write_data[LENGTHS_W-1:0];
               CSR_PATTERN_0: pattern_cfg[0] = csr_write_data;
               CSR_PATTERN_1: pattern_cfg[1] = csr_write_data;
               CSR_PATTERN_2: pattern_cfg[2] = csr_write_data;
               CSR_PATTERN_3: pattern_cfg[3] = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_report();
         if (req_valid && !req_stall) scan_text_byte(req_text_byte, req_final_byte);
      end
      pending_count = pending_reports.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the substring finder testbench: clock, reset, register settings, text stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mpsf_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int BYTE_TARGET = 400;
   localparam int PHASE_BYTES = 45;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;
   logic                    req_valid;
   logic                    req_stall;
   logic [BYTE_W-1:0]       req_text_byte;
   logic                    req_final_byte;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_result_kind;
   logic [SLOT_W-1:0]       rsp_pattern_slot;
   logic [RESULT_POS_W-1:0] rsp_start_position;
   logic [TOTAL_W-1:0]      rsp_match_total;
   logic                    rsp_run_end;

   int mismatch_count;
   int pending_count;
   int match_reports;
   int total_reports;

   logic [LENGTHS_W-1:0] lengths_now;
   logic [PATTERN_W-1:0] patterns_now [REG_SLOTS];
   logic [BYTE_W-1:0]    alphabet [3];
   int bytes_sent;
   int texts_sent;
   int settings_used;
   int burst_left;
   int idle_cycles;
   int stall_hold;
   int stall_mode;

   multi_pattern_substring_finder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_pattern_slot   (rsp_pattern_slot),
      .rsp_start_position (rsp_start_position),
      .rsp_match_total    (rsp_match_total),
      .rsp_run_end        (rsp_run_end)
   );

   substring_match_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_pattern_slot   (rsp_pattern_slot),
      .rsp_start_position (rsp_start_position),
      .rsp_match_total    (rsp_match_total),
      .rsp_run_end        (rsp_run_end),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .match_reports      (match_reports),
      .total_reports      (total_reports)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else begin
         if (stall_hold == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_hold = $urandom_range(8, 60);
         end
         stall_hold--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL multi_pattern_substring_finder_unit");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [ACTIVE_W-1:0] active,
                                input logic [LENGTHS_W-1:0] lengths,
                                input logic [PATTERN_W-1:0] p0, p1, p2, p3);
      logic [CSR_DATA_W-1:0] noise;
      noise           = {$urandom, $urandom};
      lengths_now     = lengths;
      patterns_now[0] = p0;
      patterns_now[1] = p1;
      patterns_now[2] = p2;
      patterns_now[3] = p3;
      write_reg(CSR_ACTIVE, {noise[CSR_DATA_W-1:ACTIVE_W], active});
      write_reg(CSR_LENGTHS, {noise[CSR_DATA_W-1:LENGTHS_W], lengths});
      write_reg(CSR_PATTERN_0, p0);
      write_reg(CSR_PATTERN_1, p1);
      write_reg(CSR_PATTERN_2, p2);
      write_reg(CSR_PATTERN_3, p3);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(input logic [BYTE_W-1:0] text_bytes [$]);
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
      texts_sent++;
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_text();
      logic [BYTE_W-1:0] text_q [$];
      int target;
      int slot;
      int plen;
      int cut;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 14);
      while (text_q.size() < target) begin
         case ($urandom_range(0, 9))
            0: text_q.push_back(BYTE_W'($urandom));
            1, 2, 3: begin
               slot = $urandom_range(0, REG_SLOTS - 1);
               plen = int'(lengths_now[LEN_W*slot +: LEN_W]);
               if (plen == 0 || plen > 8) plen = $urandom_range(1, 8);
               cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
               for (int i = 0; i < cut; i++)
                  text_q.push_back(patterns_now[slot][BYTE_W*i +: BYTE_W]);
            end
            default: text_q.push_back(alphabet[$urandom_range(0, 2)]);
         endcase
      end
      send_text(text_q);
   endtask

   task automatic run_random_phase();
      logic [ACTIVE_W-1:0]  active;
      logic [LENGTHS_W-1:0] lengths;
      logic [PATTERN_W-1:0] pats [REG_SLOTS];
      int phase_start;
      foreach (alphabet[k]) alphabet[k] = BYTE_W'($urandom);
      active = ($urandom_range(0, 3) == 0) ? ACTIVE_W'($urandom_range(0, 7)) : ACTIVE_W'(4);
      for (int s = 0; s < REG_SLOTS; s++) begin
         case ($urandom_range(0, 9))
            0: lengths[LEN_W*s +: LEN_W] = '0;
            1: lengths[LEN_W*s +: LEN_W] = LEN_W'($urandom_range(9, 15));
            default: lengths[LEN_W*s +: LEN_W] = LEN_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 9))
            0: pats[s] = '1;
            1: pats[s] = '0;
            default:
               for (int b = 0; b < 8; b++) pats[s][BYTE_W*b +: BYTE_W] = alphabet[$urandom_range(0, 2)];
         endcase
      end
      if (settings_used % 5 == 1) lengths = '1;
      if (settings_used % 5 == 3) lengths = 16'h8888;
      load_settings(active, lengths, pats[0], pats[1], pats[2], pats[3]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_text();
      finish_phase();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ACTIVE;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_text_byte    = '0;
      req_final_byte   = 1'b0;
      rsp_stall        = 1'b0;
      bytes_sent       = 0;
      texts_sent       = 0;
      settings_used    = 0;
      burst_left       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      load_settings(3'd4, 16'h3821, 64'h5555_5555_5555_55AA, 64'h0000_0000_0000_AAAA,
                    64'hAAAA_2211_FF00_FF00, 64'h0000_0000_00AA_AA22);
      send_text('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h11, 8'h22, 8'hAA, 8'hAA});
      send_text('{8'hAA, 8'hAA, 8'hAA, 8'hAA});
      send_text('{8'h22, 8'hAA});
      send_text('{8'hAA});
      send_text('{8'h00});
      finish_phase();

      load_settings(3'd7, 16'h9F21, 64'h0000_0000_0000_00AA, 64'h0000_0000_0000_AAAA,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      send_text('{8'hAA, 8'hAA, 8'hAA});
      finish_phase();

      load_settings(3'd0, 16'h3821, 64'h0000_0000_0000_00AA, 64'h0000_0000_0000_AAAA,
                    64'hAAAA_2211_FF00_FF00, 64'h0000_0000_00AA_AA22);
      send_text('{8'hAA, 8'hAA});
      finish_phase();

      while (bytes_sent < BYTE_TARGET) run_random_phase();

      $display("Covered %0d text bytes in %0d texts under %0d register settings;", bytes_sent,
               texts_sent, settings_used);
      $display("checked %0d match reports and %0d end-of-text totals.", match_reports,
               total_reports);
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS multi_pattern_substring_finder_unit");
      else
         $display("FAIL multi_pattern_substring_finder_unit");
      $finish;
   end

endmodule

// ===== files.f =====
design/mpsf_pkg.sv
design/mpsf_cell.sv
design/mpsf_job_queue.sv
design/mpsf_emitter.sv
design/multi_pattern_substring_finder_unit.sv
tb/sv/substring_match_checker.sv
tb/sv/testbench.sv
